[design/assert_macros.svh]
// assertion macros for the breakpoint envelope block
// needs clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising edge, off while reset is held
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/bei_pkg.sv]
// shared types and constants of the breakpoint envelope interpolator
// no dependencies
package bei_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned VAL_W   = 17;
  localparam int unsigned CURVE_W = 2;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned IN_W    = 56;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned NODE_W  = 7;

  localparam logic [VAL_W-1:0] VAL_ONE  = 17'h10000;
  localparam logic [17:0]      SMOOTH_K = 18'd196608;

  localparam logic [CURVE_W-1:0] CURVE_LINEAR = 2'd0;
  localparam logic [CURVE_W-1:0] CURVE_SMOOTH = 2'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_EVAL   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef struct packed {
    logic [TICK_W-1:0]  tick;
    logic [VAL_W-1:0]   value;
    logic [CURVE_W-1:0] curve;
  } point_t;

endpackage

[design/breakpoint_envelope_interpolator_top.sv]
// breakpoint envelope interpolator: sorted breakpoint table in one memory
// depends on bei_pkg and assert_macros.svh
//
// channel  dir  payload
// s_axis   in   tuser: func[1:0]; tdata: tick[31:0] new_value[48:32] curve[50:49]
// m_axis   out  tdata: level[16:0] status[17] node_count[24:18]
//
// one item at a time; the table memory has a registered read port and one write port
// search: read and check states per breakpoint visited, walking up from index 0
// insert/remove then shift later breakpoints one by one; evaluate between breakpoints
// runs a 16-bit divide, a multiply if smooth, a blend; no clearing pass after reset
// a finished result waits in the output register; the next item is taken meanwhile
`include "assert_macros.svh"

module breakpoint_envelope_interpolator_top #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [bei_pkg::IN_W-1:0] s_axis_tdata,  // tick, new_value, curve
  input  logic [bei_pkg::FUNC_W-1:0] s_axis_tuser, // func
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [bei_pkg::OUT_W-1:0] m_axis_tdata  // level, status, node_count
);
  import bei_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_SCHK   = 4'd2;
  localparam logic [3:0] S_INS_RD = 4'd3;
  localparam logic [3:0] S_INS_WR = 4'd4;
  localparam logic [3:0] S_REM_RD = 4'd5;
  localparam logic [3:0] S_REM_WR = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_MUL1   = 4'd8;
  localparam logic [3:0] S_MUL2   = 4'd9;
  localparam logic [3:0] S_BLEND  = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  // table memory
  point_t          mem [MAX_POINTS];
  point_t          rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  point_t          mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  logic [3:0]          state_q, state_d;
  logic [CW-1:0]       i_q, i_d, pos_q, pos_d, count_q, count_d;
  func_e               func_q, func_d;
  logic [TICK_W-1:0]   key_q, key_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [CURVE_W-1:0]  curve_q, curve_d;
  point_t              prev_q, prev_d, right_q, right_d;
  logic [TICK_W-1:0]   rem_q, rem_d, span_q, span_d;
  logic [FRAC_W-1:0]   quo_q, quo_d, f2_q, f2_d;
  logic [3:0]          dstep_q, dstep_d;
  logic [VAL_W-1:0]    w_q, w_d;
  logic [VAL_W-1:0]    res_level_q, res_level_d;
  logic                res_status_q, res_status_d;
  logic                out_valid_q, out_valid_d;
  logic [VAL_W-1:0]    out_level_q, out_level_d;
  logic                out_status_q, out_status_d;
  logic [CW-1:0]       out_count_q, out_count_d;

  logic                in_fire, stop, eq;
  logic [TICK_W:0]     rem_sh;
  logic [17:0]         k;
  logic [33:0]         prod_sm, prod_bl;
  logic [VAL_W-1:0]    diff, step;
  logic [VAL_W-1:0]    in_val;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_val        = s_axis_tdata[48:32];

  assign eq     = (rdata_q.tick == key_q);
  assign stop   = (func_q == FUNC_EVAL) ? (rdata_q.tick > key_q) : (rdata_q.tick >= key_q);
  assign rem_sh = {rem_q, 1'b0};
  assign k      = SMOOTH_K - {1'b0, quo_q, 1'b0};
  assign prod_sm = 34'(f2_q) * 34'(k);
  assign diff   = (right_q.value >= prev_q.value) ? (right_q.value - prev_q.value)
                                                  : (prev_q.value - right_q.value);
  assign prod_bl = 34'(diff) * 34'(w_q);
  assign step   = prod_bl[32:16];

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    pos_d        = pos_q;
    count_d      = count_q;
    func_d       = func_q;
    key_d        = key_q;
    val_d        = val_q;
    curve_d      = curve_q;
    prev_d       = prev_q;
    right_d      = right_q;
    rem_d        = rem_q;
    span_d       = span_q;
    quo_d        = quo_q;
    f2_d         = f2_q;
    dstep_d      = dstep_q;
    w_d          = w_q;
    res_level_d  = res_level_q;
    res_status_d = res_status_q;
    out_level_d  = out_level_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    mem_we       = 1'b0;
    mem_waddr    = i_q[AW-1:0];
    mem_raddr    = i_q[AW-1:0];
    mem_wdata    = '{tick: key_q, value: val_q, curve: curve_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          func_d       = func_e'(s_axis_tuser);
          key_d        = s_axis_tdata[31:0];
          val_d        = (in_val > VAL_ONE) ? VAL_ONE : in_val;
          curve_d      = s_axis_tdata[50:49];
          i_d          = '0;
          res_level_d  = '0;
          res_status_d = 1'b0;
          state_d      = (func_e'(s_axis_tuser) == FUNC_NOP) ? S_FIN : S_SRD;
        end
      end
      S_SRD: begin
        if (i_q == count_q) begin
          // walked past the last breakpoint
          unique case (func_q)
            FUNC_INSERT: begin
              if (count_q == CNT_MAX) begin
                res_status_d = 1'b1;
                state_d      = S_FIN;
              end else begin
                pos_d   = i_q;
                state_d = S_INS_RD;
              end
            end
            FUNC_EVAL: begin
              res_level_d = (count_q == '0) ? VAL_ONE : prev_q.value;
              state_d     = S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (!stop) begin
          prev_d  = rdata_q;
          i_d     = i_q + 1'b1;
          state_d = S_SRD;
        end else begin
          unique case (func_q)
            FUNC_INSERT: begin
              if (eq) begin
                mem_we  = 1'b1;
                state_d = S_FIN;
              end else if (count_q == CNT_MAX) begin
                res_status_d = 1'b1;
                state_d      = S_FIN;
              end else begin
                pos_d   = i_q;
                i_d     = count_q;
                state_d = S_INS_RD;
              end
            end
            FUNC_REMOVE: begin
              state_d = eq ? S_REM_RD : S_FIN;
            end
            FUNC_EVAL: begin
              right_d = rdata_q;
              if (i_q == '0) begin
                res_level_d = rdata_q.value;
                state_d     = S_FIN;
              end else if (prev_q.curve != CURVE_LINEAR && prev_q.curve != CURVE_SMOOTH) begin
                res_level_d = prev_q.value;
                state_d     = S_FIN;
              end else begin
                rem_d   = key_q - prev_q.tick;
                span_d  = rdata_q.tick - prev_q.tick;
                quo_d   = '0;
                dstep_d = '0;
                state_d = S_DIV;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_INS_RD: begin
        mem_raddr = AW'(i_q - 1'b1);
        if (i_q == pos_q) begin
          mem_we  = 1'b1;
          count_d = count_q + 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        i_d       = i_q - 1'b1;
        state_d   = S_INS_RD;
      end
      S_REM_RD: begin
        mem_raddr = AW'(i_q + 1'b1);
        if (CW'(i_q + 1'b1) == count_q) begin
          count_d = count_q - 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_REM_WR;
        end
      end
      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        i_d       = i_q + 1'b1;
        state_d   = S_REM_RD;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_sh >= {1'b0, span_q}) begin
          rem_d = TICK_W'(rem_sh - {1'b0, span_q});
          quo_d = {quo_q[FRAC_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[TICK_W-1:0];
          quo_d = {quo_q[FRAC_W-2:0], 1'b0};
        end
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == 4'd15) begin
          state_d = (prev_q.curve == CURVE_SMOOTH) ? S_MUL1 : S_BLEND;
          w_d     = {1'b0, quo_d};
        end
      end
      S_MUL1: begin
        f2_d    = FRAC_W'((32'(quo_q) * 32'(quo_q)) >> FRAC_W);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        w_d     = (prod_sm[33:16] > 18'(VAL_ONE)) ? VAL_ONE : prod_sm[32:16];
        state_d = S_BLEND;
      end
      S_BLEND: begin
        res_level_d = (right_q.value >= prev_q.value) ? (prev_q.value + step)
                                                      : (prev_q.value - step);
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_level_d  = res_level_q;
          out_status_d = res_status_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    pos_q        <= pos_d;
    func_q       <= func_d;
    key_q        <= key_d;
    val_q        <= val_d;
    curve_q      <= curve_d;
    prev_q       <= prev_d;
    right_q      <= right_d;
    rem_q        <= rem_d;
    span_q       <= span_d;
    quo_q        <= quo_d;
    f2_q         <= f2_d;
    dstep_q      <= dstep_d;
    w_q          <= w_d;
    res_level_q  <= res_level_d;
    res_status_q <= res_status_d;
    out_level_q  <= out_level_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, NODE_W'(out_count_q), out_status_q, out_level_q};

  `ASSERT_CLK(a_count_bound, count_q <= CNT_MAX, "breakpoint count above table size")
  `ASSERT_IMPL(a_count_step, count_q != $past(count_q),
    (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1),
    "breakpoint count moved by more than one")
  `ASSERT_IMPL(a_full_status, out_valid_q && out_status_q, out_count_q == CNT_MAX,
    "insert dropped while table not full")

endmodule
